>>> rtl/core/frb_pkg.sv
// shared types and constants for the fragment reassembly buffer
`timescale 1ns / 1ps

package frb_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);

    localparam int OP_W     = 2;
    localparam int OFF_W    = 11;
    localparam int LEN_W    = 11;
    localparam int TOT_W    = 12;
    localparam int TIME_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int RADDR_W  = 10;
    localparam int STAT_W   = 3;
    localparam int CNT_W    = 16;

    localparam logic [OP_W-1:0] OP_HEADER = 2'd0;
    localparam logic [OP_W-1:0] OP_DATA   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_TOTAL   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DUP     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_IGNORED = 3'd4;

    localparam logic signed [TOT_W-1:0] TOTAL_UNKNOWN = -12'sd1;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic [OFF_W-1:0]         frag_offset;
        logic [LEN_W-1:0]         frag_length;
        logic signed [TOT_W-1:0]  total_length;
        logic [TIME_W-1:0]        arrival_time;
        logic [BYTE_W-1:0]        byte_value;
        logic [RADDR_W-1:0]       read_address;
        logic                     read_limited;
    } frb_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [BYTE_W-1:0]        read_byte;
        logic [CNT_W-1:0]         received_count;
        logic signed [TOT_W-1:0]  known_total;
        logic [TIME_W-1:0]        last_time;
    } frb_out_t;

    // request to the byte store and received map
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_byte;
    } frb_mem_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rd_byte;
        logic              rd_mark;
        logic              ready;
    } frb_mem_rsp_t;

endpackage

>>> rtl/core/frb_mem.sv
// byte store and received map with clearing pass after reset
`timescale 1ns / 1ps

module frb_mem
    import frb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  frb_mem_req_t req,
    output frb_mem_rsp_t rsp
);

    logic [BYTE_W-1:0] store_mem [CAPACITY];
    logic              map_mem   [CAPACITY];

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;
    logic              clr_busy_reg;
    logic              clr_busy_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_byte;
    logic              wr_mark;
    logic [BYTE_W-1:0] rd_byte_reg;
    logic              rd_mark_reg;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(CAPACITY - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // clearing pass owns the write port until it finishes
    always_comb
    begin
        if (clr_busy_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_byte = '0;
            wr_mark = 1'b0;
        end
        else
        begin
            wr_en   = req.wr_en;
            wr_addr = req.wr_addr;
            wr_byte = req.wr_byte;
            wr_mark = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_byte;
            map_mem[wr_addr]   <= wr_mark;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_byte_reg <= store_mem[req.rd_addr];
            rd_mark_reg <= map_mem[req.rd_addr];
        end
    end

    assign rsp.rd_byte = rd_byte_reg;
    assign rsp.rd_mark = rd_mark_reg;
    assign rsp.ready   = !clr_busy_reg;

`ifndef SYNTH
    a_no_access_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !req.rd_en && !req.wr_en)
        else $error("store accessed during clearing pass");

    a_clear_ends_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_busy_reg |=> !clr_busy_reg)
        else $error("clearing pass restarted");

    a_clear_end_count: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_busy_reg) |-> clr_cnt_reg == '0)
        else $error("clearing pass ended early");
`endif

endmodule

>>> rtl/core/fragment_reassembly_buffer_unit.sv
// fragment reassembly buffer: one packet rebuilt into a byte store with a received map
// result: an accepted item word moves to the exec state, which waits until the result register
// is free, then checks, writes back and loads it; the accept issues the memory read, and no new
// item is accepted before the exec state returns to idle
// reset: a clearing pass over every entry zeroes the store and map; no item is accepted meanwhile
`timescale 1ns / 1ps

module fragment_reassembly_buffer_unit
    import frb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  frb_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output frb_out_t result
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    frb_in_t  item_reg;
    frb_out_t result_reg;
    frb_out_t result_next;
    logic     result_valid_reg;
    logic     result_valid_next;

    logic [CNT_W-1:0]        received_total_reg;
    logic [CNT_W-1:0]        received_total_next;
    logic signed [TOT_W-1:0] packet_total_reg;
    logic signed [TOT_W-1:0] packet_total_next;
    logic [TIME_W-1:0]       last_arrival_reg;
    logic [TIME_W-1:0]       last_arrival_next;
    logic [OFF_W-1:0]        write_position_reg;
    logic [OFF_W-1:0]        write_position_next;
    logic [LEN_W-1:0]        bytes_remaining_reg;
    logic [LEN_W-1:0]        bytes_remaining_next;

    frb_mem_req_t mem_req;
    frb_mem_rsp_t mem_rsp;

    logic              accept;
    logic              commit;
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] read_byte;
    logic [OFF_W:0]    span_end;
    logic [CNT_W:0]    count_sum;
    logic              data_write;

    frb_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rsp   (mem_rsp)
    );

    assign item_ready = (state_reg == ST_IDLE) && mem_rsp.ready;
    assign accept     = item_valid && item_ready;
    assign commit     = (state_reg == ST_EXEC) && (!result_valid_reg || result_ready);

    assign span_end  = {1'b0, item_reg.frag_offset} + {1'b0, item_reg.frag_length};
    assign count_sum = {1'b0, received_total_reg} + (CNT_W + 1)'(item_reg.frag_length);

    always_comb
    begin
        status               = STAT_IGNORED;
        read_byte            = '0;
        data_write           = 1'b0;
        received_total_next  = received_total_reg;
        packet_total_next    = packet_total_reg;
        last_arrival_next    = last_arrival_reg;
        write_position_next  = write_position_reg;
        bytes_remaining_next = bytes_remaining_reg;
        unique case (item_reg.opcode)
            OP_HEADER:
            begin
                bytes_remaining_next = '0;
                if (span_end > (OFF_W + 1)'(CAPACITY))
                begin
                    status = STAT_RANGE;
                end
                else if (item_reg.total_length > $signed(TOT_W'(CAPACITY)))
                begin
                    status = STAT_TOTAL;
                end
                // offset at capacity has no map bit
                else if ((item_reg.frag_offset < OFF_W'(CAPACITY)) && mem_rsp.rd_mark)
                begin
                    status = STAT_DUP;
                end
                else
                begin
                    status               = STAT_OK;
                    received_total_next  = count_sum[CNT_W] ? '1 : count_sum[CNT_W-1:0];
                    last_arrival_next    = item_reg.arrival_time;
                    write_position_next  = item_reg.frag_offset;
                    bytes_remaining_next = item_reg.frag_length;
                    if (!item_reg.total_length[TOT_W-1])
                    begin
                        packet_total_next = item_reg.total_length;
                    end
                end
            end
            OP_DATA:
            begin
                if ((bytes_remaining_reg != '0) && (write_position_reg < OFF_W'(CAPACITY)))
                begin
                    status               = STAT_OK;
                    data_write           = 1'b1;
                    write_position_next  = write_position_reg + 1'b1;
                    bytes_remaining_next = bytes_remaining_reg - 1'b1;
                end
            end
            OP_READ:
            begin
                if ({1'b0, item_reg.read_address} >= (RADDR_W + 1)'(CAPACITY))
                begin
                    status = STAT_RANGE;
                end
                else if (item_reg.read_limited && (packet_total_reg[TOT_W-1] ||
                         (TOT_W'(item_reg.read_address) >= $unsigned(packet_total_reg))))
                begin
                    status = STAT_RANGE;
                end
                else
                begin
                    status    = STAT_OK;
                    read_byte = mem_rsp.rd_byte;
                end
            end
            default:
            begin
                status = STAT_IGNORED;
            end
        endcase
    end

    always_comb
    begin
        result_next.status         = status;
        result_next.read_byte      = read_byte;
        result_next.received_count = received_total_next;
        result_next.known_total    = packet_total_next;
        result_next.last_time      = last_arrival_next;
    end

    // read issued at accept so the map bit and byte are ready in the exec cycle
    always_comb
    begin
        mem_req.rd_en   = accept;
        mem_req.rd_addr = (item.opcode == OP_READ) ? ADDR_W'(item.read_address)
                                                   : item.frag_offset[ADDR_W-1:0];
        mem_req.wr_en   = commit && data_write;
        mem_req.wr_addr = write_position_reg[ADDR_W-1:0];
        mem_req.wr_byte = item_reg.byte_value;
    end

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (accept)
        begin
            state_next = ST_EXEC;
        end
        if (commit)
        begin
            state_next        = ST_IDLE;
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            result_valid_reg    <= 1'b0;
            received_total_reg  <= '0;
            packet_total_reg    <= TOTAL_UNKNOWN;
            last_arrival_reg    <= '0;
            write_position_reg  <= '0;
            bytes_remaining_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (commit)
            begin
                received_total_reg  <= received_total_next;
                packet_total_reg    <= packet_total_next;
                last_arrival_reg    <= last_arrival_next;
                write_position_reg  <= write_position_next;
                bytes_remaining_reg <= bytes_remaining_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (commit)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted word did not enter exec");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        received_total_reg >= $past(received_total_reg))
        else $error("received count went down");

    a_window_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, write_position_reg} + {1'b0, bytes_remaining_reg}) <= (OFF_W + 1)'(CAPACITY))
        else $error("data window runs past capacity");

    a_commit_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> result_valid_reg)
        else $error("result lost at commit");
`endif

endmodule
